// ===== rtl/core/qlma_pkg.sv =====
// ----------------------------------------------------------------------------
// qlma_pkg
// Shared constants and types of the qualified load moving average block.
// ----------------------------------------------------------------------------
package qlma_pkg;

	// Averaging window depth and the number of qualified words before averaging.
	localparam int WINDOW       = 50;
	localparam int STABLE_COUNT = 100;

	// Contact is qualified when the summed probabilities exceed 2.5 (x256).
	localparam int CONTACT_LIMIT = 640;

	// Field widths.
	localparam int PROB_W   = 9;
	localparam int FORCE_W  = 16;
	localparam int WEIGHT_W = 15;

	// Derived widths.
	localparam int PSUM_W   = PROB_W + 2;
	localparam int TOTAL_W  = FORCE_W + 2;
	localparam int SUM_W    = 24;
	localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int STABLE_W = $clog2(STABLE_COUNT + 1);
	localparam int DVS_W    = FILL_W + 4;
	localparam int CNT_W    = $clog2(SUM_W);

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_MIN_WEIGHT = 1'b0;

	// Sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_UPD  = 6'b000010,
		ST_PREP = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_FIX  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

endpackage

// ===== rtl/core/qlma_ram.sv =====
// ----------------------------------------------------------------------------
// qlma_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module qlma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/qualified_load_moving_average.sv =====
// ----------------------------------------------------------------------------
// qualified_load_moving_average
// Contact-gated moving average of the total leg force, turned into a held
// weight estimate through an iterative divide and a lower clamp.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  sample    in         sample_valid/sample_stall   prob_leg0..3, force_leg0..3
//  result    out        result_valid/result_stall   weight, updated
//  config    in         APB (psel/penable/pready)   min_weight at byte address 0
//
// A word that does not start an average update is accepted, then loaded into
// the output register. A word that updates the average passes through the
// window read, the running sum, the divide set-up, the restoring divider at
// one quotient bit per cycle for SUM_W bits, sign and clamp, and the load of
// the output register.
// sample_stall is high whenever the sequencer is busy. A finished result waits
// in the output register while the next word is accepted; the sequencer only
// holds in its last state if that register is still full and stalled.
// Reset clears the counters, the running sum, the held weight and min_weight;
// the window memory needs no clearing since the fill count guards its reads.
// ----------------------------------------------------------------------------
module qualified_load_moving_average
	import qlma_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic [PROB_W-1:0]         prob_leg0,
	input  logic [PROB_W-1:0]         prob_leg1,
	input  logic [PROB_W-1:0]         prob_leg2,
	input  logic [PROB_W-1:0]         prob_leg3,
	input  logic signed [FORCE_W-1:0] force_leg0,
	input  logic signed [FORCE_W-1:0] force_leg1,
	input  logic signed [FORCE_W-1:0] force_leg2,
	input  logic signed [FORCE_W-1:0] force_leg3,

	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [WEIGHT_W-1:0] weight,
	output logic                      updated,

	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready
);

	// Control state.
	state_t                     state_q;
	logic [STABLE_W-1:0]        stable_q;
	logic [POS_W-1:0]           wpos_q;
	logic [FILL_W-1:0]          fill_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [WEIGHT_W-1:0] held_q;
	logic signed [WEIGHT_W-1:0] min_weight_q;
	logic                       upd_q;
	logic                       result_valid_q;

	// Datapath registers.
	logic signed [TOTAL_W-1:0]  total_q;
	logic [DVS_W-1:0]           dvsr_q;
	logic [DVS_W-1:0]           rem_q;
	logic [SUM_W-1:0]           dq_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       negq_q;
	logic signed [WEIGHT_W-1:0] weight_q;
	logic                       updated_q;

	// Window memory.
	logic                       ram_wr_en;
	logic                       ram_rd_en;
	logic [TOTAL_W-1:0]         ram_rd_data;

	// Accept-cycle logic.
	logic                       accept;
	logic                       cfg_wr;
	logic                       out_free;
	logic [PSUM_W-1:0]          psum;
	logic                       qual;
	logic [STABLE_W-1:0]        stable_nxt;
	logic signed [TOTAL_W-1:0]  total;

	// Running sum update.
	logic signed [TOTAL_W-1:0]  old_val;
	logic signed [TOTAL_W:0]    delta;
	logic [POS_W-1:0]           wpos_nxt;

	// Divider step.
	logic [DVS_W:0]             rem_sh;
	logic [DVS_W+1:0]           trial;
	logic                       ge;

	// Sign and clamp.
	logic signed [SUM_W:0]      qs;
	logic signed [SUM_W:0]      minx;

	assign pready       = 1'b1;
	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign cfg_wr       = psel && penable && pwrite && pready;
	assign out_free     = !result_valid_q || !result_stall;

	assign result_valid = result_valid_q;
	assign weight       = weight_q;
	assign updated      = updated_q;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MIN_WEIGHT) begin
			prdata = PDATA_W'(min_weight_q);
		end
	end

	// Contact qualification and the stable counter.
	assign psum = PSUM_W'(prob_leg0) + PSUM_W'(prob_leg1) +
		PSUM_W'(prob_leg2) + PSUM_W'(prob_leg3);
	assign qual = (psum > PSUM_W'(CONTACT_LIMIT));

	always_comb begin
		stable_nxt = '0;
		if (qual) begin
			if (stable_q < STABLE_W'(STABLE_COUNT)) begin
				stable_nxt = stable_q + 1'b1;
			end else begin
				stable_nxt = stable_q;
			end
		end
	end

	assign total = TOTAL_W'(force_leg0) + TOTAL_W'(force_leg1) +
		TOTAL_W'(force_leg2) + TOTAL_W'(force_leg3);

	// The oldest entry leaves the sum only once the window is full.
	assign old_val  = (fill_q == FILL_W'(WINDOW)) ? $signed(ram_rd_data) : '0;
	assign delta    = (TOTAL_W + 1)'(total_q) - (TOTAL_W + 1)'(old_val);
	assign wpos_nxt = (wpos_q == POS_W'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;

	assign ram_rd_en = accept;
	assign ram_wr_en = (state_q == ST_UPD);

	// Restoring divider: one quotient bit per cycle.
	assign rem_sh = {rem_q, dq_q[SUM_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, dvsr_q};
	assign ge     = !trial[DVS_W+1];

	assign qs   = negq_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
	assign minx = (SUM_W + 1)'(min_weight_q);

	qlma_ram #(
		.WIDTH(TOTAL_W),
		.DEPTH(WINDOW)
	) u_window (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (wpos_q),
		.wr_data (total_q),
		.rd_en   (ram_rd_en),
		.rd_addr (wpos_q),
		.rd_data (ram_rd_data)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			stable_q       <= '0;
			wpos_q         <= '0;
			fill_q         <= '0;
			sum_q          <= '0;
			held_q         <= '0;
			min_weight_q   <= '0;
			upd_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_MIN_WEIGHT)) begin
				min_weight_q <= pwdata[WEIGHT_W-1:0];
			end

			// A new word enters the output register as soon as it is free,
			// which may be in the same cycle the previous one leaves.
			if ((state_q == ST_FIN) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						stable_q <= stable_nxt;
						if (!qual) begin
							wpos_q <= '0;
							fill_q <= '0;
							sum_q  <= '0;
						end
						if (stable_nxt == STABLE_W'(STABLE_COUNT)) begin
							state_q <= ST_UPD;
						end else begin
							upd_q   <= 1'b0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_UPD: begin
					if (fill_q != FILL_W'(WINDOW)) begin
						fill_q <= fill_q + 1'b1;
					end
					sum_q   <= sum_q + SUM_W'(delta);
					wpos_q  <= wpos_nxt;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (qs < minx) begin
						held_q <= min_weight_q;
					end else begin
						held_q <= qs[WEIGHT_W-1:0];
					end
					upd_q   <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					total_q <= total;
				end
			end
			ST_PREP: begin
				// The quotient of -sum is negative when the sum is positive.
				negq_q <= !sum_q[SUM_W-1];
				dq_q   <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
				dvsr_q <= {fill_q, 3'b000} + {2'b00, fill_q, 1'b0};
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
				dq_q  <= {dq_q[SUM_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_FIN: begin
				if (out_free) begin
					weight_q  <= held_q;
					updated_q <= upd_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== bench/qualified_load_moving_average_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qualified_load_moving_average_tb
// Self-checking bench for the contact-gated moving-average weight estimator.
// Sample words are driven through the valid/stall channel while a predictor in
// the bench tracks the contact run, the force window and the held weight. Each
// result word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module qualified_load_moving_average_tb
	import qlma_pkg::*;
();

	// Half of the 10 ns clock period.
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 10;
	// Long enough for an averaging word to pass through the block, with a margin.
	localparam int SETTLE_CYCLES = 40;
	// Cycles without any accepted word before the run is declared hung.
	localparam int HANG_LIMIT = 4000;
	localparam int MAX_WAIT = 10;
	localparam logic [PADDR_W-1:0] MIN_WEIGHT_ADDR = PADDR_W'(REG_MIN_WEIGHT) << 2;

	// One sample word: four probabilities and four vertical forces.
	typedef struct packed {
		logic [3:0][PROB_W-1:0]  prob;
		logic [3:0][FORCE_W-1:0] leg_force;
	} sample_t;

	// One result word as the block should present it.
	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic                       updated;
	} weight_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       sample_valid;
	logic                       sample_stall;
	logic [PROB_W-1:0]          prob_leg0, prob_leg1, prob_leg2, prob_leg3;
	logic signed [FORCE_W-1:0]  force_leg0, force_leg1, force_leg2, force_leg3;
	logic                       result_valid;
	logic                       result_stall;
	logic signed [WEIGHT_W-1:0] weight;
	logic                       updated;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [PADDR_W-1:0]         paddr;
	logic [PDATA_W-1:0]         pwdata;
	logic [PDATA_W-1:0]         prdata;
	logic                       pready;

	qualified_load_moving_average u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.prob_leg0    (prob_leg0),
		.prob_leg1    (prob_leg1),
		.prob_leg2    (prob_leg2),
		.prob_leg3    (prob_leg3),
		.force_leg0   (force_leg0),
		.force_leg1   (force_leg1),
		.force_leg2   (force_leg2),
		.force_leg3   (force_leg3),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.weight       (weight),
		.updated      (updated),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Predictor state. It mirrors what the block keeps: the count of qualified
	// words in a row, the ring of force totals with its running sum, the held
	// weight and the lower clamp last written over the configuration port.
	int unsigned               contact_run;
	logic signed [TOTAL_W-1:0] force_window [WINDOW];
	int unsigned               window_head;
	int unsigned               window_fill;
	longint                    window_sum;
	logic signed [WEIGHT_W-1:0] held_estimate;
	logic signed [WEIGHT_W-1:0] weight_floor;

	// Predictions wait here, oldest first, until the matching result word.
	weight_result_t expected_weights [$];

	// Idle control for both channels, switched per burst so that some stretches
	// run back to back and others are full of gaps.
	bit tx_idle;
	bit rx_idle;
	int rx_hold;

	int samples_sent;
	int results_seen;
	int updates_seen;
	int floors_used;
	int mismatch_count;
	int hang_count;

	// The clock free-runs from time zero.
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Prints one line per mismatch and counts it; the run carries on.
	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Steps the predictor by one accepted sample word and returns the result
	// word that the block owes for it. Contact is qualified only strictly
	// above the limit; anything else empties the window and restarts the run.
	function automatic weight_result_t estimate_weight(sample_t s);
		int unsigned    psum;
		longint         total;
		longint         quotient;
		weight_result_t r;
		psum = s.prob[0] + s.prob[1] + s.prob[2] + s.prob[3];
		if (psum > CONTACT_LIMIT) begin
			if (contact_run < STABLE_COUNT)
				contact_run++;
		end else begin
			contact_run = 0;
			window_head = 0;
			window_fill = 0;
			window_sum  = 0;
		end
		r.updated = 1'b0;
		if (contact_run >= STABLE_COUNT) begin
			total = longint'($signed(s.leg_force[0])) + longint'($signed(s.leg_force[1]))
				+ longint'($signed(s.leg_force[2])) + longint'($signed(s.leg_force[3]));
			// Once the window is full the oldest total drops out of the sum.
			if (window_fill < WINDOW)
				window_fill++;
			else
				window_sum -= force_window[window_head];
			force_window[window_head] = TOTAL_W'(total);
			window_sum += total;
			window_head = (window_head + 1 >= WINDOW) ? 0 : window_head + 1;
			// SystemVerilog division truncates toward zero, as the block must.
			quotient = -window_sum / (longint'(window_fill) * 10);
			if (quotient < weight_floor)
				quotient = weight_floor;
			held_estimate = WEIGHT_W'(quotient);
			r.updated = 1'b1;
		end
		r.weight = held_estimate;
		return r;
	endfunction

	// Offers one sample word and returns at the clock edge that accepts it.
	// The valid line is only lowered when a gap is drawn, so back-to-back words
	// keep it high across the boundary.
	task automatic send_sample(sample_t s);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		prob_leg0    <= s.prob[0];
		prob_leg1    <= s.prob[1];
		prob_leg2    <= s.prob[2];
		prob_leg3    <= s.prob[3];
		force_leg0   <= s.leg_force[0];
		force_leg1   <= s.leg_force[1];
		force_leg2   <= s.leg_force[2];
		force_leg3   <= s.leg_force[3];
		do
			@(posedge clk);
		while (!(sample_valid && !sample_stall));
		expected_weights.push_back(estimate_weight(s));
		samples_sent++;
	endtask

	// Builds a sample word from plain numbers for the directed cases.
	function automatic sample_t pack_legs(int p0, int p1, int p2, int p3,
		int f0, int f1, int f2, int f3);
		sample_t s;
		s.prob[0]      = PROB_W'(p0);
		s.prob[1]      = PROB_W'(p1);
		s.prob[2]      = PROB_W'(p2);
		s.prob[3]      = PROB_W'(p3);
		s.leg_force[0] = FORCE_W'(f0);
		s.leg_force[1] = FORCE_W'(f1);
		s.leg_force[2] = FORCE_W'(f2);
		s.leg_force[3] = FORCE_W'(f3);
		return s;
	endfunction

	// Draws a random sample word that is, or is not, in qualified contact.
	// Force styles: any 16-bit value, a realistic standing load, or extremes.
	function automatic sample_t random_sample(bit contact, int style);
		sample_t     s;
		int unsigned psum;
		int unsigned top;
		top = $urandom_range(0, 1) ? 511 : 256;
		do begin
			psum = 0;
			for (int i = 0; i < 4; i++) begin
				s.prob[i] = PROB_W'($urandom_range(0, top));
				psum += s.prob[i];
			end
		end while ((psum > CONTACT_LIMIT) != contact);
		for (int i = 0; i < 4; i++) begin
			case (style)
				0: s.leg_force[i] = FORCE_W'($urandom);
				1: s.leg_force[i] = FORCE_W'(-int'($urandom_range(0, 1500)));
				default: begin
					case ($urandom_range(0, 3))
						0: s.leg_force[i] = 16'sh8000;
						1: s.leg_force[i] = 16'sh7fff;
						2: s.leg_force[i] = '0;
						default: s.leg_force[i] = '1;
					endcase
				end
			endcase
		end
		return s;
	endfunction

	// Lets every outstanding result word drain, then waits out the block's
	// longest internal latency so that it is truly idle.
	task automatic drain_results();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (expected_weights.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes min_weight over the configuration port while the block is idle and
	// reads it back. The write lands on the access-phase edge.
	task automatic set_weight_floor(logic signed [WEIGHT_W-1:0] floor_value);
		logic [PDATA_W-1:0] readback;
		drain_results();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MIN_WEIGHT_ADDR;
		pwdata  <= PDATA_W'(floor_value);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		weight_floor = floor_value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback[WEIGHT_W-1:0] !== floor_value)
			report_mismatch("min_weight readback",
				longint'($signed(readback[WEIGHT_W-1:0])), floor_value);
		floors_used++;
	endtask

	// Probability sums on both sides of the contact limit, the largest and
	// smallest field values, and alternating bit patterns. None of these words
	// reaches the stable count, so the held weight must stay put.
	task automatic test_contact_threshold();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_sample(pack_legs(0, 0, 0, 0, 0, 0, 0, 0));
		send_sample(pack_legs(511, 511, 511, 511, 32767, 32767, 32767, 32767));
		send_sample(pack_legs(160, 160, 160, 160, -32768, -32768, -32768, -32768));
		send_sample(pack_legs(160, 160, 160, 161, -32768, 32767, -1, 0));
		send_sample(pack_legs(256, 256, 256, 256, 32767, -32768, 32767, -32768));
		send_sample(pack_legs(511, 129, 0, 0, -1, -1, -1, -1));
		send_sample(pack_legs(511, 130, 0, 0, 1, 2, 4, 8));
		send_sample(pack_legs(0, 0, 0, 0, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_sample(pack_legs(255, 255, 255, 255, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
		send_sample(pack_legs(1, 2, 4, 8, 0, 0, 0, 0));
		send_sample(pack_legs(256, 0, 256, 129, 100, -100, 100, -100));
		send_sample(pack_legs(170, 170, 170, 170, -4000, -4000, -4000, -4000));
		send_sample(pack_legs(510, 0, 0, 131, 0, 0, 0, 0));
		send_sample(pack_legs(2, 256, 256, 128, -7, -7, -7, -7));
	endtask

	// Builds up a full contact run, then pushes extreme totals through the
	// window: the first averaged word, a window filled with the largest
	// positive totals, a wrap of the ring, a window saturated with the most
	// negative totals, and finally a break in contact that empties it.
	task automatic test_window_extremes();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (int i = 0; i < STABLE_COUNT - 1; i++)
			send_sample(random_sample(1'b1, 0));
		send_sample(pack_legs(256, 256, 256, 256, -32768, -32768, -32768, -32768));
		for (int i = 0; i < WINDOW - 1; i++)
			send_sample(pack_legs(511, 511, 511, 511, 32767, 32767, 32767, 32767));
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		for (int i = 0; i < 60; i++)
			send_sample(random_sample(1'b1, 0));
		for (int i = 0; i < WINDOW + 5; i++)
			send_sample(pack_legs(200, 200, 200, 200, -32768, -32768, -32768, -32768));
		send_sample(pack_legs(160, 160, 160, 160, 0, 0, 0, 0));
		send_sample(pack_legs(256, 256, 256, 256, -32768, -32768, -32768, -32768));
	endtask

	// Random bursts. Most are contact runs long enough to reach averaging, many
	// also long enough to wrap the window, some are cut short, and a few are broken
	// by a single word out of contact; stray words out of contact sit between bursts.
	task automatic test_random_bursts(int n_items);
		int done;
		int run;
		int style;
		int noise;
		bit broken;
		done = 0;
		while (done < n_items) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				run = $urandom_range(1, STABLE_COUNT - 1);
			else
				run = $urandom_range(STABLE_COUNT, STABLE_COUNT + WINDOW + 70);
			style = $urandom_range(0, 2);
			for (int i = 0; i < run && done < n_items; i++) begin
				broken = ($urandom_range(0, 149) == 0);
				send_sample(random_sample(!broken, style));
				done++;
			end
			noise = $urandom_range(1, 3);
			for (int i = 0; i < noise && done < n_items; i++) begin
				send_sample(random_sample(1'b0, $urandom_range(0, 2)));
				done++;
			end
		end
	endtask

	// Checks every accepted result word against the oldest prediction.
	always @(posedge clk) begin : check_results
		weight_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (expected_weights.size() == 0) begin
				report_mismatch("result word with nothing pending, weight", weight, 0);
			end else begin
				want = expected_weights.pop_front();
				if (weight !== want.weight)
					report_mismatch("weight", weight, want.weight);
				if (updated !== want.updated)
					report_mismatch("updated", updated, want.updated);
				if (want.updated)
					updates_seen++;
			end
		end
	end

	// Result-side back-pressure, only while rx_idle is set. A pending result word
	// is held off for a drawn number of cycles; with nothing pending the stall
	// line toggles at random to land on every phase of the block's work. When a
	// word is released, a fresh wait is drawn for the one that may follow it.
	always @(negedge clk) begin
		if (!rx_idle) begin
			result_stall <= 1'b0;
			rx_hold = 0;
		end else if (result_valid) begin
			if (rx_hold > 0) begin
				result_stall <= 1'b1;
				rx_hold--;
			end else begin
				result_stall <= 1'b0;
				rx_hold = $urandom_range(0, MAX_WAIT);
			end
		end else begin
			result_stall <= ($urandom_range(0, 3) == 0);
			rx_hold = $urandom_range(0, MAX_WAIT);
		end
	end

	// Watchdog: a long stretch with no accepted word on any port means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (psel && penable && pready))
				hang_count = 0;
			else
				hang_count++;
			if (hang_count >= HANG_LIMIT) begin
				$display("Timed out after %0d idle cycles.", hang_count);
				$display("qualified_load_moving_average: mismatch");
				$finish;
			end
		end
	end

	initial begin
		// Every input is known from time zero, while reset is held low.
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		prob_leg0    = '0;
		prob_leg1    = '0;
		prob_leg2    = '0;
		prob_leg3    = '0;
		force_leg0   = '0;
		force_leg1   = '0;
		force_leg2   = '0;
		force_leg3   = '0;
		result_stall = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		tx_idle      = 1'b0;
		rx_idle      = 1'b0;
		rx_hold      = 0;
		contact_run  = 0;
		window_head  = 0;
		window_fill  = 0;
		window_sum   = 0;
		held_estimate = '0;
		weight_floor  = '0;
		for (int i = 0; i < WINDOW; i++)
			force_window[i] = '0;
		samples_sent   = 0;
		results_seen   = 0;
		updates_seen   = 0;
		floors_used    = 0;
		mismatch_count = 0;
		hang_count     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The first tests run with min_weight at its reset value, then with the
		// most negative floor so that negative weights come through unclamped.
		test_contact_threshold();
		set_weight_floor(-16384);
		test_window_extremes();

		// Random phases under different floors, including the largest one, which
		// pins every fresh weight to the floor, and one small positive floor that
		// clamps realistic standing loads part of the time.
		set_weight_floor(16383);
		test_random_bursts(215);
		set_weight_floor(300);
		test_random_bursts(215);
		set_weight_floor(WEIGHT_W'($urandom_range(0, 32767)));
		test_random_bursts(215);
		set_weight_floor(0);
		test_random_bursts(215);
		set_weight_floor(-16384);
		test_random_bursts(215);

		drain_results();
		$display("Covered %0d sample words under %0d min_weight settings.",
			samples_sent, floors_used);
		$display("Checked %0d result words, %0d of them with a freshly averaged weight.",
			results_seen, updates_seen);
		if (mismatch_count == 0 && expected_weights.size() == 0) begin
			$display("qualified_load_moving_average: match");
		end else begin
			$display("qualified_load_moving_average: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/qlma_pkg.sv
rtl/core/qlma_ram.sv
rtl/core/qualified_load_moving_average.sv
bench/qualified_load_moving_average_tb.sv
